// ----- rtl/sp2c_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, types and constant tables for the polar-to-Cartesian scan block.
// Used by sp2c_front, sp2c_fifo, sp2c_cordic and scan_polar_to_cartesian.
package sp2c_pkg;

  localparam int RANGE_BITS   = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int IDX_BITS     = 16;
  localparam int INT_BITS     = 16;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;

  // CORDIC gain compensation in Q30
  localparam int GAIN_BITS = 30;
  localparam logic [GAIN_BITS-1:0] GAIN_Q30 = 30'd652032874;

  localparam int PROD_BITS = RANGE_BITS + GAIN_BITS;
  localparam int P_BITS    = PROD_BITS - 14;
  localparam int XW        = RANGE_BITS + 20;
  localparam int ZW        = 33;
  localparam int STEPS     = 16;
  localparam int OUT_BITS  = RANGE_BITS + 1;

  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_ANGLE = 2'd0,
    REG_ANGLE_STEP  = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_BITS-1:0]   idx;
    logic [ANGLE_BITS-1:0] ang;
    logic [RANGE_BITS-1:0] range_mm;
    logic [INT_BITS-1:0]   inten;
  } item_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    logic [INT_BITS-1:0] inten;
  } meta_t;

  // atan(2^-i) in units of 2pi/2^32
  function automatic logic signed [ZW-1:0] atan_lut(input int unsigned i);
    logic signed [ZW-1:0] a;
    case (i)
      0:       a = 33'sd536870912;
      1:       a = 33'sd316933406;
      2:       a = 33'sd167458907;
      3:       a = 33'sd85004756;
      4:       a = 33'sd42667331;
      5:       a = 33'sd21354465;
      6:       a = 33'sd10680862;
      7:       a = 33'sd5340245;
      8:       a = 33'sd2670163;
      9:       a = 33'sd1335087;
      10:      a = 33'sd667544;
      11:      a = 33'sd333772;
      12:      a = 33'sd166886;
      13:      a = 33'sd83443;
      14:      a = 33'sd41722;
      15:      a = 33'sd20861;
      default: a = '0;
    endcase
    return a;
  endfunction

  // sign-extend a register word and reduce it to the beam angle width
  function automatic logic [ANGLE_BITS-1:0] ext_angle(input logic [CFG_BITS-1:0] v);
    logic signed [31:0] s;
    s = 32'(signed'(v));
    return s[ANGLE_BITS-1:0];
  endfunction

endpackage

// ----- rtl/sp2c_front.sv -----
`timescale 1ns / 1ps
// Front end: configuration registers, beam angle and sample index tracking,
// and drop of empty samples. Depends on sp2c_pkg.
module sp2c_front import sp2c_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    start_of_scan_i,
  input  logic                    range_infinite_i,
  input  logic [RANGE_BITS-1:0]   distance_i,
  input  logic [INT_BITS-1:0]     intensity_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output item_t                   item_o
);

  logic [ANGLE_BITS-1:0] start_angle_q, start_angle_d;
  logic [ANGLE_BITS-1:0] angle_step_q, angle_step_d;
  logic [ANGLE_BITS-1:0] beam_angle_q, beam_angle_d;
  logic [IDX_BITS-1:0]   index_q, index_d;
  logic                  accept;
  logic [IDX_BITS-1:0]   idx;
  logic [ANGLE_BITS-1:0] ang;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign accept      = in_valid_i & ~q_full_i;

  assign idx = start_of_scan_i ? '0 : index_q;
  assign ang = start_of_scan_i ? start_angle_q : beam_angle_q;

  always_comb begin
    start_angle_d = start_angle_q;
    angle_step_d  = angle_step_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_START_ANGLE: start_angle_d = ext_angle(cfg_data_i);
        REG_ANGLE_STEP:  angle_step_d  = ext_angle(cfg_data_i);
        default: ;
      endcase
    end
  end

  // the index and angle advance on every beat, dropped or not
  assign index_d      = accept ? idx + IDX_BITS'(1) : index_q;
  assign beam_angle_d = accept ? ang + angle_step_q : beam_angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_angle_q <= '0;
      angle_step_q  <= '0;
      beam_angle_q  <= '0;
      index_q       <= '0;
    end else begin
      start_angle_q <= start_angle_d;
      angle_step_q  <= angle_step_d;
      beam_angle_q  <= beam_angle_d;
      index_q       <= index_d;
    end
  end

  assign push_o          = accept & ~range_infinite_i & (distance_i != '0);
  assign item_o.idx      = idx;
  assign item_o.ang      = ang;
  assign item_o.range_mm = distance_i;
  assign item_o.inten    = intensity_i;

endmodule

// ----- rtl/sp2c_fifo.sv -----
`timescale 1ns / 1ps
// Short queue of samples between the front end and the CORDIC pipeline.
// Depends on sp2c_pkg.
module sp2c_fifo import sp2c_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  vld_o,
  output item_t item_o
);

  item_t                mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wptr_q, wptr_d;
  logic [QPTR_BITS-1:0] rptr_q, rptr_d;
  logic [QPTR_BITS:0]   cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (cnt_q == (QPTR_BITS+1)'(QDEPTH));
  assign vld_o   = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & vld_o;

  assign wptr_d = do_push ? wptr_q + QPTR_BITS'(1) : wptr_q;
  assign rptr_d = do_pop ? rptr_q + QPTR_BITS'(1) : rptr_q;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (QPTR_BITS+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (QPTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !vld_o)) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_BITS+1)'(QDEPTH)) else $error("queue count out of range");

endmodule

// ----- rtl/sp2c_cordic.sv -----
`timescale 1ns / 1ps
// Back end: gain multiply, pipelined CORDIC rotation, rounding, saturation and
// the output register. Depends on sp2c_pkg.
module sp2c_cordic import sp2c_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_vld_i,
  input  item_t                      q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OUT_BITS-1:0] x_mm_o,
  output logic signed [OUT_BITS-1:0] y_mm_o,
  output logic [INT_BITS-1:0]        point_intensity_o,
  output logic [IDX_BITS-1:0]        sample_index_o
);

  localparam int RW = XW - 16;
  localparam logic signed [RW-1:0] LIM = RW'((64'd1 << RANGE_BITS) - 64'd1);
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

  logic                        en;
  logic                        vld_q  [STEPS+1];
  meta_t                       meta_q [STEPS+1];
  logic signed [XW-1:0]        x_q    [STEPS+1];
  logic signed [XW-1:0]        y_q    [STEPS+1];
  logic signed [ZW-1:0]        z_q    [STEPS+1];
  logic [P_BITS-1:0]           p_q;
  logic                        neg_q;
  logic [31:0]                 u;
  logic                        flip;
  logic [31:0]                 uf;
  logic [PROD_BITS-1:0]        prod;
  logic signed [XW-1:0]        pe;
  logic                        z0_pos;
  logic                        out_valid_q;
  logic signed [OUT_BITS-1:0]  x_mm_q, y_mm_q;
  meta_t                       out_meta_q;

  function automatic logic signed [OUT_BITS-1:0] finish(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] s;
    logic signed [RW-1:0] r;
    s = v + XW'(32768);
    r = s[XW-1:16];
    if (r > LIM) begin
      r = LIM;
    end else if (r < -LIM) begin
      r = -LIM;
    end
    return r[OUT_BITS-1:0];
  endfunction

  // the whole pipeline holds while a finished point waits downstream
  assign en      = ~out_valid_q | ~out_stall_i;
  assign q_pop_o = en & q_vld_i;

  // fold the angle into [-pi/2, pi/2) and remember to negate the start vector
  assign u    = 32'(q_item_i.ang) << (32 - ANGLE_BITS);
  assign flip = u[31] ^ u[30];
  assign uf   = flip ? (u ^ 32'h8000_0000) : u;
  assign prod = PROD_BITS'(q_item_i.range_mm) * PROD_BITS'(GAIN_Q30);

  // stage 0: gain multiply
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q         <= prod[PROD_BITS-1:14];
      neg_q       <= flip;
      z_q[0]      <= signed'({uf[31], uf});
      meta_q[0]   <= '{idx: q_item_i.idx, inten: q_item_i.inten};
      x_q[0]      <= '0;
      y_q[0]      <= '0;
    end
  end

  // stage 1: first rotation with y = 0, negation folded in
  assign pe     = signed'({{(XW-P_BITS){1'b0}}, p_q});
  assign z0_pos = ~z_q[0][ZW-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[1]    <= neg_q ? -pe : pe;
      y_q[1]    <= (z0_pos ^ neg_q) ? pe : -pe;
      z_q[1]    <= z0_pos ? z_q[0] - atan_lut(0) : z_q[0] + atan_lut(0);
      meta_q[1] <= meta_q[0];
    end
  end

  for (genvar k = 2; k <= STEPS; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!z_q[k-1][ZW-1]) begin
          x_q[k] <= x_q[k-1] - (y_q[k-1] >>> (k-1));
          y_q[k] <= y_q[k-1] + (x_q[k-1] >>> (k-1));
          z_q[k] <= z_q[k-1] - atan_lut(k-1);
        end else begin
          x_q[k] <= x_q[k-1] + (y_q[k-1] >>> (k-1));
          y_q[k] <= y_q[k-1] - (x_q[k-1] >>> (k-1));
          z_q[k] <= z_q[k-1] + atan_lut(k-1);
        end
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= STEPS; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= q_vld_i;
      for (int i = 1; i <= STEPS; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_valid_q <= vld_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_mm_q     <= finish(x_q[STEPS]);
      y_mm_q     <= finish(y_q[STEPS]);
      out_meta_q <= meta_q[STEPS];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign x_mm_o            = x_mm_q;
  assign y_mm_o            = y_mm_q;
  assign point_intensity_o = out_meta_q.inten;
  assign sample_index_o    = out_meta_q.idx;

  a_x_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> x_mm_o != OUT_MIN) else $error("x not saturated");
  a_y_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> y_mm_o != OUT_MIN) else $error("y not saturated");
  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q[STEPS]) && !$past(q_pop_o))
    else $error("pipeline moved while output stalled");

endmodule

// ----- rtl/scan_polar_to_cartesian.sv -----
`timescale 1ns / 1ps
// Top level of the lidar scan to Cartesian point converter.
// Depends on sp2c_pkg, sp2c_front, sp2c_fifo and sp2c_cordic.
//
// Accepts one range sample per cycle. Each sample carries its own beam angle
// (start_angle at a start of scan, else the previous angle plus angle_step)
// and index; infinite or zero-distance samples advance both but give no point.
// Every other sample yields x = d*cos, y = d*sin in mm, rounded and saturated,
// with its intensity and index, after it passes the four-entry input queue,
// the gain multiply register, sixteen CORDIC stages and the output register.
// Sustained rate is one sample per cycle; in_stall_o rises only once the
// queue has filled behind a stalled output.
// Configuration writes are always ready and should be made while idle.
module scan_polar_to_cartesian import sp2c_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [CFG_BITS-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       start_of_scan_i,
  input  logic                       range_infinite_i,
  input  logic [RANGE_BITS-1:0]      distance_i,
  input  logic [INT_BITS-1:0]        intensity_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OUT_BITS-1:0] x_mm_o,
  output logic signed [OUT_BITS-1:0] y_mm_o,
  output logic [INT_BITS-1:0]        point_intensity_o,
  output logic [IDX_BITS-1:0]        sample_index_o
);

  logic  q_full;
  logic  push;
  item_t push_item;
  logic  q_vld;
  item_t q_item;
  logic  q_pop;

  sp2c_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .start_of_scan_i  (start_of_scan_i),
    .range_infinite_i (range_infinite_i),
    .distance_i       (distance_i),
    .intensity_i      (intensity_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .item_o           (push_item)
  );

  sp2c_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .vld_o  (q_vld),
    .item_o (q_item)
  );

  sp2c_cordic u_cordic (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_vld_i           (q_vld),
    .q_item_i          (q_item),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .x_mm_o            (x_mm_o),
    .y_mm_o            (y_mm_o),
    .point_intensity_o (point_intensity_o),
    .sample_index_o    (sample_index_o)
  );

endmodule

// ----- bench/tb_scan_polar_to_cartesian.sv -----
`timescale 1ns / 1ps
// Self-checking bench for scan_polar_to_cartesian: range samples in, rotated points out.
// Depends on sp2c_pkg and the RTL of scan_polar_to_cartesian.
module tb_scan_polar_to_cartesian;
  import sp2c_pkg::*;

  localparam int     CLK_PERIOD       = 10;
  localparam int     RESET_CYCLES     = 8;
  localparam int     SETTLE_CYCLES    = 24;
  localparam int     LONG_HOLD_CYCLES = 150;
  localparam int     WATCHDOG_LIMIT   = 2000;
  localparam int     RANDOM_PHASES    = 10;
  localparam int     PHASE_SAMPLES    = 50;
  localparam int     MAX_REPORTS      = 40;
  localparam longint CORDIC_GAIN      = 64'sd652032874;
  localparam longint FULL_SCALE       = (64'sd1 <<< RANGE_BITS) - 1;

  // register indexes that map to nothing
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic                  sos;
    logic                  no_return;
    logic [RANGE_BITS-1:0] range_mm;
    logic [INT_BITS-1:0]   inten;
  } sample_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic [INT_BITS-1:0]        inten;
    logic [IDX_BITS-1:0]        idx;
  } point_t;

  logic                       clk_i            = 1'b0;
  logic                       rst_ni           = 1'b0;
  logic                       cfg_valid_i      = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]    cfg_index_i      = '0;
  logic [CFG_BITS-1:0]        cfg_data_i       = '0;
  logic                       in_valid_i       = 1'b0;
  logic                       in_stall_o;
  logic                       start_of_scan_i  = 1'b0;
  logic                       range_infinite_i = 1'b0;
  logic [RANGE_BITS-1:0]      distance_i       = '0;
  logic [INT_BITS-1:0]        intensity_i      = '0;
  logic                       out_valid_o;
  logic                       out_stall_i      = 1'b0;
  logic signed [OUT_BITS-1:0] x_mm_o;
  logic signed [OUT_BITS-1:0] y_mm_o;
  logic [INT_BITS-1:0]        point_intensity_o;
  logic [IDX_BITS-1:0]        sample_index_o;

  scan_polar_to_cartesian u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .start_of_scan_i   (start_of_scan_i),
    .range_infinite_i  (range_infinite_i),
    .distance_i        (distance_i),
    .intensity_i       (intensity_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .x_mm_o            (x_mm_o),
    .y_mm_o            (y_mm_o),
    .point_intensity_o (point_intensity_o),
    .sample_index_o    (sample_index_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // atan(2^-i) in units of 2pi/2^32
  longint atan_turn [0:STEPS-1] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861
  };

  // scan state mirrored from the block
  logic [ANGLE_BITS-1:0] scan_start_angle = '0;
  logic [ANGLE_BITS-1:0] scan_angle_step  = '0;
  logic [ANGLE_BITS-1:0] next_angle       = '0;
  logic [IDX_BITS-1:0]   next_index       = '0;

  sample_t pending_samples [$];
  point_t  expected_points [$];

  int  mismatches      = 0;
  int  samples_taken   = 0;
  int  samples_dropped = 0;
  int  points_checked  = 0;
  int  reg_writes      = 0;
  int  input_held      = 0;
  int  quiet_cycles    = 0;
  int  send_idle_pct   = 0;
  int  recv_idle_pct   = 0;
  int  send_gap        = 0;
  int  recv_stall_left = 0;
  int  hold_count      = 0;
  bit  in_taken        = 1'b0;
  bit  long_hold_go    = 1'b0;
  bit  long_hold_done  = 1'b0;

  function automatic int idle_length();
    return ($urandom_range(9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic signed [OUT_BITS-1:0] clamp_mm(input longint acc);
    longint r;
    r = (acc + 64'sd32768) >>> 16;
    if (r > FULL_SCALE) r = FULL_SCALE;
    else if (r < -FULL_SCALE) r = -FULL_SCALE;
    return r[OUT_BITS-1:0];
  endfunction

  function automatic void rotate_beam(input logic [RANGE_BITS-1:0] range_mm,
                                      input logic [ANGLE_BITS-1:0] angle,
                                      output logic signed [OUT_BITS-1:0] x_mm,
                                      output logic signed [OUT_BITS-1:0] y_mm);
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    logic [31:0] turn;
    logic [31:0] probe;
    turn = 32'(angle) << (32 - ANGLE_BITS);
    x = (longint'(range_mm) * CORDIC_GAIN) >>> 14;
    y = 0;
    // fold the left half plane onto the right one
    probe = turn + 32'h4000_0000;
    if (probe[31]) begin
      x = -x;
      turn = turn - 32'h8000_0000;
    end
    z = longint'(signed'(turn));
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_turn[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_turn[i];
      end
    end
    x_mm = clamp_mm(x);
    y_mm = clamp_mm(y);
  endfunction

  function automatic void note_reg_write(input logic [CFG_IDX_BITS-1:0] idx,
                                         input logic [CFG_BITS-1:0] value);
    case (idx)
      REG_START_ANGLE: scan_start_angle = value[ANGLE_BITS-1:0];
      REG_ANGLE_STEP:  scan_angle_step  = value[ANGLE_BITS-1:0];
      default: ;
    endcase
  endfunction

  // advance index and angle, and queue the point this sample yields, if any
  function automatic void take_sample(input sample_t s);
    logic [IDX_BITS-1:0]        idx;
    logic [ANGLE_BITS-1:0]      ang;
    logic signed [OUT_BITS-1:0] xs;
    logic signed [OUT_BITS-1:0] ys;
    point_t                     p;
    idx = s.sos ? '0 : next_index;
    ang = s.sos ? scan_start_angle : next_angle;
    next_index = idx + 1'b1;
    next_angle = ang + scan_angle_step;
    if (s.no_return || s.range_mm == '0) begin
      samples_dropped++;
    end else begin
      rotate_beam(s.range_mm, ang, xs, ys);
      p.x = xs;
      p.y = ys;
      p.inten = s.inten;
      p.idx = idx;
      expected_points.push_back(p);
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // both sides: predict from register writes and samples, check each point out
  always @(posedge clk_i) begin : watch_ports
    sample_t s;
    point_t  want;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        note_reg_write(cfg_index_i, cfg_data_i);
        reg_writes++;
      end
      if (in_valid_i && in_stall_o) input_held++;
      if (in_taken) begin
        s.sos = start_of_scan_i;
        s.no_return = range_infinite_i;
        s.range_mm = distance_i;
        s.inten = intensity_i;
        take_sample(s);
        samples_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("unexpected point x=%0d y=%0d idx=%0d",
                                    x_mm_o, y_mm_o, sample_index_o));
        end else begin
          want = expected_points.pop_front();
          if (x_mm_o !== want.x)
            report_mismatch($sformatf("idx %0d x_mm got %0d want %0d",
                                      want.idx, x_mm_o, want.x));
          if (y_mm_o !== want.y)
            report_mismatch($sformatf("idx %0d y_mm got %0d want %0d",
                                      want.idx, y_mm_o, want.y));
          if (point_intensity_o !== want.inten)
            report_mismatch($sformatf("idx %0d intensity got %0h want %0h",
                                      want.idx, point_intensity_o, want.inten));
          if (sample_index_o !== want.idx)
            report_mismatch($sformatf("sample_index got %0d want %0d",
                                      sample_index_o, want.idx));
          points_checked++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // sample driver: hold a stalled beat, otherwise idle or advance
  always @(negedge clk_i) begin : drive_samples
    sample_t s;
    if (!in_valid_i || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        s = pending_samples.pop_front();
        start_of_scan_i  <= s.sos;
        range_infinite_i <= s.no_return;
        distance_i       <= s.range_mm;
        intensity_i      <= s.inten;
        in_valid_i       <= 1'b1;
        send_gap = ($urandom_range(99) < send_idle_pct) ? idle_length() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // point receiver: random stalls, plus one long hold on request
  always @(negedge clk_i) begin
    if (!long_hold_go) long_hold_done = 1'b0;
    if (long_hold_go && !long_hold_done) begin
      out_stall_i <= 1'b1;
      hold_count++;
      if (hold_count >= LONG_HOLD_CYCLES) begin
        long_hold_done = 1'b1;
        hold_count = 0;
      end
    end else if (recv_stall_left > 0) begin
      out_stall_i <= 1'b1;
      recv_stall_left--;
    end else if ($urandom_range(99) < recv_idle_pct) begin
      out_stall_i <= 1'b1;
      recv_stall_left = idle_length() - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_sample(input bit sos, input bit no_return,
                            input logic [RANGE_BITS-1:0] range_mm,
                            input logic [INT_BITS-1:0] inten);
    sample_t s;
    s.sos = sos;
    s.no_return = no_return;
    s.range_mm = range_mm;
    s.inten = inten;
    pending_samples.push_back(s);
  endtask

  // wait until every sample is taken and every point is back, then settle
  task automatic drain();
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_points.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CFG_BITS-1:0] pick_angle();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return CFG_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [RANGE_BITS-1:0] pick_range();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 20) return RANGE_BITS'(16'hFFFF - $urandom_range(15));
    if (r < 40) return RANGE_BITS'($urandom_range(1, 255));
    return RANGE_BITS'($urandom);
  endfunction

  // one scan of random content; a stray start of scan now and then
  task automatic queue_scan(input int len, input bit fresh);
    for (int k = 0; k < len; k++)
      add_sample((k == 0 && fresh) || ($urandom_range(99) < 3),
                 $urandom_range(99) < 8, pick_range(), INT_BITS'($urandom));
  endtask

  initial begin
    int queued;
    int len;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // registers at reset values, no start of scan yet
    add_sample(1'b0, 1'b0, 16'hFFFF, 16'h0000);
    add_sample(1'b0, 1'b0, 16'h0001, 16'hFFFF);
    add_sample(1'b0, 1'b1, 16'h0064, 16'h0005);
    drain();

    // quarter turns from pi, including both quadrant folds; unmapped writes ignored
    write_reg(REG_START_ANGLE, 16'h8000);
    write_reg(REG_ANGLE_STEP, 16'h4000);
    write_reg(REG_SPARE_2, 16'h1234);
    write_reg(REG_SPARE_3, 16'hFFFF);
    add_sample(1'b1, 1'b0, 16'hFFFF, 16'hAAAA);
    add_sample(1'b0, 1'b0, 16'hFFFF, 16'h5555);
    add_sample(1'b0, 1'b0, 16'hFFFF, 16'h0001);
    add_sample(1'b0, 1'b0, 16'hFFFF, 16'h8000);
    add_sample(1'b0, 1'b0, 16'h0000, 16'h1111);
    add_sample(1'b0, 1'b1, 16'h0000, 16'h2222);
    add_sample(1'b0, 1'b1, 16'hFFFF, 16'h3333);
    add_sample(1'b0, 1'b0, 16'h0001, 16'h7FFF);
    drain();

    write_reg(REG_START_ANGLE, 16'h7FFF);
    write_reg(REG_ANGLE_STEP, 16'h8000);
    add_sample(1'b1, 1'b0, 16'hFFFF, 16'h0F0F);
    add_sample(1'b0, 1'b0, 16'hFFFF, 16'hF0F0);
    add_sample(1'b0, 1'b0, 16'h8000, 16'h00FF);
    add_sample(1'b1, 1'b0, 16'h7FFF, 16'hFF00);
    drain();

    // angle_step applies at once, start_angle only at the next start of scan
    write_reg(REG_ANGLE_STEP, 16'h7FFF);
    write_reg(REG_START_ANGLE, 16'h2000);
    add_sample(1'b0, 1'b0, 16'hFFFF, 16'h1234);
    add_sample(1'b0, 1'b0, 16'h00FF, 16'h4321);
    add_sample(1'b1, 1'b0, 16'hFFFE, 16'hBEEF);
    add_sample(1'b0, 1'b0, 16'h0002, 16'hCAFE);
    drain();

    // short scan with a unit step: the angle wraps through zero
    write_reg(REG_START_ANGLE, 16'hFFFA);
    write_reg(REG_ANGLE_STEP, 16'h0001);
    add_sample(1'b1, 1'b0, 16'h0400, 16'h0000);
    for (int k = 1; k < 12; k++)
      add_sample(1'b0, k > 8, pick_range() | 16'h0001, INT_BITS'($urandom));
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if ($urandom_range(1)) begin
        write_reg(REG_START_ANGLE, pick_angle());
        write_reg(REG_ANGLE_STEP, pick_angle());
      end else begin
        write_reg(REG_ANGLE_STEP, pick_angle());
        write_reg(REG_START_ANGLE, pick_angle());
      end
      if ($urandom_range(3) == 0) write_reg(REG_SPARE_2 | CFG_IDX_BITS'($urandom_range(1)),
                                            CFG_BITS'($urandom));
      send_idle_pct = (ph == 2 || ph == 4) ? 0 : $urandom_range(3) * 20;
      recv_idle_pct = (ph == 2) ? 0 : $urandom_range(3) * 20;
      queued = 0;
      while (queued < PHASE_SAMPLES) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        queue_scan(len, queued > 0 || $urandom_range(1));
        queued += len;
      end
      if (ph == 4) begin
        // hold the output off so the pipeline and the input queue fill
        long_hold_go = 1'b1;
        wait (long_hold_done);
        long_hold_go = 1'b0;
      end
      drain();
    end

    if (expected_points.size() != 0)
      report_mismatch($sformatf("%0d points never arrived", expected_points.size()));
    $display("covered %0d samples (%0d dropped), %0d points checked, %0d register writes",
             samples_taken, samples_dropped, points_checked, reg_writes);
    $display("input held off by backpressure for %0d cycles, %0d mismatches",
             input_held, mismatches);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
